### hw/rtl/hfd_pkg.sv
// Shared types and constants of the Huffman file decoder.
// Used by the front queue, the decode engine, the response stage and the top level.
package hfd_pkg;

   localparam int NodeCount   = 256;
   localparam int MaxSymbols  = 256;
   localparam int LengthBytes = 4;
   localparam int QueueDepth  = 4;
   localparam int QueueAw     = $clog2(QueueDepth);

   typedef enum logic [2:0] {
      PH_COUNT,
      PH_PAIRS,
      PH_CODES,
      PH_LENGTH,
      PH_DATA,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_NODE_RD,
      S_NODE_EX,
      S_CLR_NEW,
      S_SKIP_RD,
      S_SKIP_CHK,
      S_FLUSH
   } eng_state_type;

   typedef struct packed {
      logic       sof;
      logic [7:0] data;
   } q_item_type;

   typedef struct packed {
      logic       valid;
      q_item_type item;
   } q_out_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       done;
      logic       err;
   } res_type;

   typedef struct packed {
      logic    push;
      logic    flush;
      res_type res;
   } emit_type;

endpackage

### hw/rtl/hfd_if.sv
// Request and response channel interfaces of the Huffman file decoder.
// Valid/ready handshake with payload; no package dependency.
interface hfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_file;
   modport source (output valid, data_byte, start_of_file, input ready);
   modport sink (input valid, data_byte, start_of_file, output ready);
endinterface

interface hfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       last_of_byte;
   logic       message_done;
   logic       error;
   modport source (output valid, symbol, last_of_byte, message_done, error, input ready);
   modport sink (input valid, symbol, last_of_byte, message_done, error, output ready);
endinterface

### hw/rtl/hfd_front.sv
// Front request queue: accepts input bytes and tags start-of-file.
// Depends on hfd_pkg and hfd_req_if.
module hfd_front (
   input  logic              clock,
   input  logic              reset,
   hfd_req_if.sink           req_ch,
   input  logic              pop,
   output hfd_pkg::q_out_type q_out
);
   hfd_pkg::q_item_type          mem_ff [hfd_pkg::QueueDepth];
   logic [hfd_pkg::QueueAw-1:0]  wr_ff, rd_ff;
   logic [hfd_pkg::QueueAw:0]    cnt_ff, cnt_in;
   logic                         push, do_pop;

   assign req_ch.ready = (cnt_ff != (hfd_pkg::QueueAw+1)'(hfd_pkg::QueueDepth));
   assign push         = req_ch.valid && req_ch.ready;
   assign do_pop       = pop && (cnt_ff != '0);
   assign q_out.valid  = (cnt_ff != '0);
   assign q_out.item   = mem_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (!push && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff].sof  <= req_ch.start_of_file;
         mem_ff[wr_ff].data <= req_ch.data_byte;
      end
   end

endmodule

### hw/rtl/hfd_engine.sv
// Decode engine: parses the header, builds the code tree and walks it per data bit.
// Depends on hfd_pkg; holds the symbol table and node memories.
module hfd_engine (
   input  logic               clock,
   input  logic               reset,
   input  hfd_pkg::q_out_type q_out,
   output logic               pop,
   input  logic               eng_ok,
   output hfd_pkg::emit_type  emit
);
   hfd_pkg::phase_type     phase_ff, phase_in, ph;
   hfd_pkg::eng_state_type st_ff, st_in;
   logic [8:0]  total_ff, total_in, idx_ff, idx_in, nf_ff, nf_in;
   logic        half_ff, half_in, more_ff, more_in;
   logic [7:0]  lo_ff, lo_in, walk_ff, walk_in, cbl_ff, cbl_in, byte_ff, byte_in;
   logic [7:0]  esym_ff, esym_in;
   logic [1:0]  lbc_ff, lbc_in;
   logic [31:0] mlen_ff, mlen_in, dcnt_ff, dcnt_in, mlen_new, dcnt_next;
   logic [2:0]  bit_ff, bit_in;

   logic [15:0] sym_mem [hfd_pkg::MaxSymbols];
   logic [19:0] node_mem [hfd_pkg::NodeCount];
   logic [15:0] sym_rd_ff, sym_wdata;
   logic [19:0] node_rd_ff, node_wdata;
   logic [7:0]  sym_waddr, sym_raddr, node_waddr, node_raddr;
   logic        sym_we, sym_re, node_we, node_re;

   logic        dir;
   logic [9:0]  ch;
   logic [2:0]  lbc_next;

   always_ff @(posedge clock) begin
      if (sym_we) sym_mem[sym_waddr] <= sym_wdata;
      if (sym_re) sym_rd_ff <= sym_mem[sym_raddr];
      if (node_we) node_mem[node_waddr] <= node_wdata;
      if (node_re) node_rd_ff <= node_mem[node_raddr];
   end

   assign dir       = byte_ff[bit_ff];
   assign ch        = dir ? node_rd_ff[19:10] : node_rd_ff[9:0];
   assign dcnt_next = dcnt_ff + 32'd1;
   assign lbc_next  = {1'b0, lbc_ff} + 3'd1;

   always_comb begin
      mlen_new = mlen_ff;
      case (lbc_ff)
         2'd0:    mlen_new[7:0]   = q_out.item.data;
         2'd1:    mlen_new[15:8]  = q_out.item.data;
         2'd2:    mlen_new[23:16] = q_out.item.data;
         default: mlen_new[31:24] = q_out.item.data;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hfd_pkg::PH_COUNT;
         st_ff    <= hfd_pkg::S_IDLE;
         total_ff <= '0;
         idx_ff   <= '0;
         half_ff  <= 1'b0;
         nf_ff    <= 9'd1;
         walk_ff  <= '0;
         cbl_ff   <= '0;
         lbc_ff   <= '0;
         mlen_ff  <= '0;
         dcnt_ff  <= '0;
         more_ff  <= 1'b0;
         bit_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         st_ff    <= st_in;
         total_ff <= total_in;
         idx_ff   <= idx_in;
         half_ff  <= half_in;
         nf_ff    <= nf_in;
         walk_ff  <= walk_in;
         cbl_ff   <= cbl_in;
         lbc_ff   <= lbc_in;
         mlen_ff  <= mlen_in;
         dcnt_ff  <= dcnt_in;
         more_ff  <= more_in;
         bit_ff   <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      byte_ff <= byte_in;
      esym_ff <= esym_in;
   end

   always_comb begin
      phase_in = phase_ff;
      st_in    = st_ff;
      total_in = total_ff;
      idx_in   = idx_ff;
      half_in  = half_ff;
      nf_in    = nf_ff;
      walk_in  = walk_ff;
      cbl_in   = cbl_ff;
      lbc_in   = lbc_ff;
      mlen_in  = mlen_ff;
      dcnt_in  = dcnt_ff;
      more_in  = more_ff;
      bit_in   = bit_ff;
      lo_in    = lo_ff;
      byte_in  = byte_ff;
      esym_in  = esym_ff;
      ph       = phase_ff;
      pop        = 1'b0;
      emit       = '0;
      sym_we     = 1'b0;
      sym_waddr  = idx_ff[7:0];
      sym_wdata  = {q_out.item.data, lo_ff};
      sym_re     = 1'b0;
      sym_raddr  = idx_ff[7:0];
      node_we    = 1'b0;
      node_waddr = walk_ff;
      node_wdata = '0;
      node_re    = 1'b0;
      node_raddr = walk_ff;

      unique case (st_ff)
         hfd_pkg::S_IDLE: begin
            if (q_out.valid) begin
               pop     = 1'b1;
               byte_in = q_out.item.data;
               bit_in  = 3'd7;
               ph      = q_out.item.sof ? hfd_pkg::PH_COUNT : phase_ff;
               phase_in = ph;
               unique case (ph)
                  hfd_pkg::PH_COUNT: begin
                     total_in   = (q_out.item.data == 8'd0) ? 9'd256 : {1'b0, q_out.item.data};
                     idx_in     = '0;
                     half_in    = 1'b0;
                     node_we    = 1'b1;
                     node_waddr = 8'd0;
                     node_wdata = '0;
                     nf_in      = 9'd1;
                     walk_in    = '0;
                     cbl_in     = '0;
                     lbc_in     = '0;
                     mlen_in    = '0;
                     dcnt_in    = '0;
                     phase_in   = hfd_pkg::PH_PAIRS;
                  end
                  hfd_pkg::PH_PAIRS: begin
                     if (!half_ff) begin
                        lo_in   = q_out.item.data;
                        half_in = 1'b1;
                     end else begin
                        sym_we  = 1'b1;
                        half_in = 1'b0;
                        if (idx_ff + 9'd1 >= total_ff) begin
                           idx_in  = '0;
                           walk_in = '0;
                           st_in   = hfd_pkg::S_SKIP_RD;
                        end else begin
                           idx_in = idx_ff + 9'd1;
                        end
                     end
                  end
                  hfd_pkg::PH_CODES, hfd_pkg::PH_DATA: st_in = hfd_pkg::S_NODE_RD;
                  hfd_pkg::PH_LENGTH: begin
                     mlen_in = mlen_new;
                     lbc_in  = lbc_next[1:0];
                     if (lbc_next >= 3'(hfd_pkg::LengthBytes)) begin
                        dcnt_in  = '0;
                        walk_in  = '0;
                        phase_in = (mlen_new != 32'd0) ? hfd_pkg::PH_DATA : hfd_pkg::PH_DONE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         hfd_pkg::S_NODE_RD: begin
            node_re = 1'b1;
            st_in   = hfd_pkg::S_NODE_EX;
         end
         hfd_pkg::S_NODE_EX: begin
            if (eng_ok) begin
               bit_in  = bit_ff - 3'd1;
               more_in = (bit_ff != 3'd0);
               st_in   = (bit_ff != 3'd0) ? hfd_pkg::S_NODE_RD : hfd_pkg::S_FLUSH;
               if (phase_ff == hfd_pkg::PH_CODES) begin
                  if (cbl_ff <= 8'd1) begin
                     if (ch[9]) begin
                        emit.push    = 1'b1;
                        emit.res.err = 1'b1;
                        phase_in     = hfd_pkg::PH_ERROR;
                        st_in        = hfd_pkg::S_FLUSH;
                     end else begin
                        node_we    = 1'b1;
                        node_wdata = dir ? {2'b11, esym_ff, node_rd_ff[9:0]}
                                         : {node_rd_ff[19:10], 2'b11, esym_ff};
                        walk_in    = '0;
                        idx_in     = idx_ff + 9'd1;
                        st_in      = hfd_pkg::S_SKIP_RD;
                     end
                  end else if (ch[9]) begin
                     if (ch[8]) begin
                        emit.push    = 1'b1;
                        emit.res.err = 1'b1;
                        phase_in     = hfd_pkg::PH_ERROR;
                        st_in        = hfd_pkg::S_FLUSH;
                     end else begin
                        walk_in = ch[7:0];
                        cbl_in  = cbl_ff - 8'd1;
                     end
                  end else if (nf_ff[8]) begin
                     emit.push    = 1'b1;
                     emit.res.err = 1'b1;
                     phase_in     = hfd_pkg::PH_ERROR;
                     st_in        = hfd_pkg::S_FLUSH;
                  end else begin
                     node_we    = 1'b1;
                     node_wdata = dir ? {2'b10, nf_ff[7:0], node_rd_ff[9:0]}
                                      : {node_rd_ff[19:10], 2'b10, nf_ff[7:0]};
                     st_in      = hfd_pkg::S_CLR_NEW;
                  end
               end else begin
                  if (!ch[9]) begin
                     emit.push    = 1'b1;
                     emit.res.err = 1'b1;
                     phase_in     = hfd_pkg::PH_ERROR;
                     st_in        = hfd_pkg::S_FLUSH;
                  end else if (ch[8]) begin
                     dcnt_in         = dcnt_next;
                     walk_in         = '0;
                     emit.push       = 1'b1;
                     emit.res.symbol = ch[7:0];
                     if (dcnt_next == mlen_ff) begin
                        emit.res.done = 1'b1;
                        phase_in      = hfd_pkg::PH_DONE;
                        st_in         = hfd_pkg::S_FLUSH;
                     end
                  end else begin
                     walk_in = ch[7:0];
                  end
               end
            end
         end
         hfd_pkg::S_CLR_NEW: begin
            node_we    = 1'b1;
            node_waddr = nf_ff[7:0];
            node_wdata = '0;
            walk_in    = nf_ff[7:0];
            nf_in      = nf_ff + 9'd1;
            cbl_in     = cbl_ff - 8'd1;
            st_in      = more_ff ? hfd_pkg::S_NODE_RD : hfd_pkg::S_FLUSH;
         end
         hfd_pkg::S_SKIP_RD: begin
            if (idx_ff < total_ff) begin
               sym_re = 1'b1;
               st_in  = hfd_pkg::S_SKIP_CHK;
            end else begin
               phase_in = hfd_pkg::PH_LENGTH;
               lbc_in   = '0;
               mlen_in  = '0;
               st_in    = hfd_pkg::S_FLUSH;
            end
         end
         hfd_pkg::S_SKIP_CHK: begin
            if (sym_rd_ff[15:8] == 8'd0) begin
               idx_in = idx_ff + 9'd1;
               st_in  = hfd_pkg::S_SKIP_RD;
            end else begin
               cbl_in  = sym_rd_ff[15:8];
               esym_in = sym_rd_ff[7:0];
               if (phase_ff == hfd_pkg::PH_PAIRS) begin
                  phase_in = hfd_pkg::PH_CODES;
                  st_in    = hfd_pkg::S_FLUSH;
               end else begin
                  st_in = more_ff ? hfd_pkg::S_NODE_RD : hfd_pkg::S_FLUSH;
               end
            end
         end
         hfd_pkg::S_FLUSH: begin
            emit.flush = 1'b1;
            if (eng_ok) st_in = hfd_pkg::S_IDLE;
         end
         default: st_in = hfd_pkg::S_IDLE;
      endcase
   end

endmodule

### hw/rtl/hfd_rsp.sv
// Response stage: holds one result until the next shows whether it ends its byte.
// Depends on hfd_pkg and hfd_rsp_if.
module hfd_rsp (
   input  logic              clock,
   input  logic              reset,
   input  hfd_pkg::emit_type emit,
   output logic              eng_ok,
   hfd_rsp_if.source         rsp_ch
);
   logic             pend_v_ff, out_v_ff, out_free, move;
   hfd_pkg::res_type pend_ff, out_ff;
   logic             out_last_ff;

   assign out_free = !out_v_ff || rsp_ch.ready;
   assign eng_ok   = !pend_v_ff || out_free;
   assign move     = pend_v_ff && out_free && (emit.push || emit.flush);

   assign rsp_ch.valid        = out_v_ff;
   assign rsp_ch.symbol       = out_ff.symbol;
   assign rsp_ch.message_done = out_ff.done;
   assign rsp_ch.error        = out_ff.err;
   assign rsp_ch.last_of_byte = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         if (move) out_v_ff <= 1'b1;
         else if (rsp_ch.ready) out_v_ff <= 1'b0;
         if (emit.push && eng_ok) pend_v_ff <= 1'b1;
         else if (emit.flush && eng_ok) pend_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_ff      <= pend_ff;
         out_last_ff <= emit.flush;
      end
      if (emit.push && eng_ok) pend_ff <= emit.res;
   end

endmodule

### hw/rtl/huffman_file_decoder.sv
// Top level of the Huffman file decoder: front queue, decode engine, response stage.
// Depends on hfd_pkg, hfd_if, hfd_front, hfd_engine and hfd_rsp.
//
//   channel  | dir | handshake       | payload
//   req_ch   | in  | valid / ready   | data_byte, start_of_file
//   rsp_ch   | out | valid / ready   | symbol, last_of_byte, message_done, error
//
// Count, pair, length and ignored bytes are consumed as they are popped. The last pair byte
// then examines symbol table entries (read then check) until it finds a coded one or runs past
// the last entry, and closes. Code and data bytes are popped, then each bit reads the node memory
// then updates it, and the byte closes; an error or the message end stops it early. Each new
// tree node adds a clearing step; each finished code examines table entries for the next one.
// Reset is synchronous; the node and symbol memories need no clearing.
// A 4-entry request queue keeps accepting, until it is full, while the engine works or results stall.
module huffman_file_decoder (
   input  logic      clock,
   input  logic      reset,
   hfd_req_if.sink   req_ch,
   hfd_rsp_if.source rsp_ch
);
   hfd_pkg::q_out_type q_out;
   hfd_pkg::emit_type  emit;
   logic               pop, eng_ok;

   hfd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .pop    (pop),
      .q_out  (q_out)
   );

   hfd_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .q_out  (q_out),
      .pop    (pop),
      .eng_ok (eng_ok),
      .emit   (emit)
   );

   hfd_rsp u_rsp (
      .clock  (clock),
      .reset  (reset),
      .emit   (emit),
      .eng_ok (eng_ok),
      .rsp_ch (rsp_ch)
   );

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.error |-> rsp_ch.symbol == 8'd0 && !rsp_ch.message_done)
      else $error("error result carries symbol or done");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.error |-> rsp_ch.last_of_byte)
      else $error("error result not last of its byte");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.message_done |-> rsp_ch.last_of_byte)
      else $error("message end not last of its byte");

endmodule
